@@ design/cfam_pkg.sv @@
`timescale 1ns / 1ps

package cfam_pkg;

    // operation select carried on the command field
    typedef enum logic
    {
        CMD_ADD = 1'b0,
        CMD_MUL = 1'b1
    } cmd_t;

endpackage

@@ design/custom_float_add_multiply.sv @@
`timescale 1ns / 1ps

// adder and multiplier for a sign / exponent / unnormalized fraction format
// input channel: command plus operands a and b, moved by in_valid / in_stall;
//   a transfer happens at a rising edge with in_valid high and in_stall low
// output channel: res_sign, res_exp, res_frac, exp_overflow, moved by
//   out_valid / out_stall in the same way
// command 0 adds, command 1 multiplies; one result for every operand pair
// pipeline: 3 register stages; a result is registered through the operand
//   compare and product stage, the align and leading-one stage, and the
//   add/subtract and normalize stage feeding the output register
// throughput: one operand pair per cycle when the receiver does not stall;
//   every stage is a plain register stage with its own valid bit
// when the receiver stalls the output register holds, stages behind it keep
//   filling empty slots, and in_stall rises once the pipeline is full
// reset clears all valid bits; the pipeline comes up empty with in_stall low
module custom_float_add_multiply #(
    parameter int FRAC_WIDTH = 18,
    parameter int EXP_WIDTH  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  command,
    input  logic                  a_sign,
    input  logic [EXP_WIDTH-1:0]  a_exp,
    input  logic [FRAC_WIDTH-1:0] a_frac,
    input  logic                  b_sign,
    input  logic [EXP_WIDTH-1:0]  b_exp,
    input  logic [FRAC_WIDTH-1:0] b_frac,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  res_sign,
    output logic [EXP_WIDTH-1:0]  res_exp,
    output logic [FRAC_WIDTH-1:0] res_frac,
    output logic                  exp_overflow
);

    localparam int PW      = 2 * FRAC_WIDTH;
    localparam int SHIFT_W = $clog2(FRAC_WIDTH + 1);
    localparam int EXT_W   = ((EXP_WIDTH > SHIFT_W) ? EXP_WIDTH : SHIFT_W) + 2;
    localparam logic [EXP_WIDTH-1:0] EXP_MAX = {EXP_WIDTH{1'b1}};

    // handshake between stages
    logic out_ready;
    logic s2_ready;
    logic s1_ready;

    // stage 1 registers
    logic                  s1_valid_reg;
    logic                  s1_mul_reg;
    logic                  s1_a_sign_reg;
    logic                  s1_b_sign_reg;
    logic [FRAC_WIDTH-1:0] s1_a_frac_reg;
    logic [FRAC_WIDTH-1:0] s1_b_frac_reg;
    logic                  s1_a_gt_reg;
    logic [EXP_WIDTH-1:0]  s1_diff_reg;
    logic [EXP_WIDTH-1:0]  s1_e_big_reg;
    logic [PW-1:0]         s1_prod_reg;
    logic [EXP_WIDTH:0]    s1_esum_reg;
    logic                  s1_zero_reg;

    logic                  s1_a_gt_next;
    logic [EXP_WIDTH-1:0]  s1_diff_next;
    logic [EXP_WIDTH-1:0]  s1_e_big_next;
    logic [PW-1:0]         s1_prod_next;
    logic [EXP_WIDTH:0]    s1_esum_next;
    logic                  s1_zero_next;

    // stage 2 registers
    logic                  s2_valid_reg;
    logic                  s2_mul_reg;
    logic                  s2_a_sign_reg;
    logic                  s2_b_sign_reg;
    logic [FRAC_WIDTH-1:0] s2_af_reg;
    logic [FRAC_WIDTH-1:0] s2_bf_reg;
    logic [EXP_WIDTH-1:0]  s2_e_big_reg;
    logic [PW-1:0]         s2_prod_reg;
    logic [EXP_WIDTH:0]    s2_esum_reg;
    logic                  s2_zero_reg;
    logic [SHIFT_W-1:0]    s2_shift_reg;

    logic [FRAC_WIDTH-1:0] s2_af_next;
    logic [FRAC_WIDTH-1:0] s2_bf_next;
    logic [SHIFT_W-1:0]    s2_shift_next;

    // output registers
    logic                  out_valid_reg;
    logic                  res_sign_reg;
    logic [EXP_WIDTH-1:0]  res_exp_reg;
    logic [FRAC_WIDTH-1:0] res_frac_reg;
    logic                  exp_overflow_reg;

    logic                  res_sign_next;
    logic [EXP_WIDTH-1:0]  res_exp_next;
    logic [FRAC_WIDTH-1:0] res_frac_next;
    logic                  exp_overflow_next;

    assign out_ready = !out_valid_reg || !out_stall;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_stall  = !s1_ready;

    // stage 1: exponent compare and difference, full product, exponent sum
    always_comb
    begin
        s1_a_gt_next  = a_exp > b_exp;
        s1_diff_next  = s1_a_gt_next ? (a_exp - b_exp) : (b_exp - a_exp);
        s1_e_big_next = s1_a_gt_next ? a_exp : b_exp;
        s1_prod_next  = PW'(a_frac) * PW'(b_frac);
        s1_esum_next  = (EXP_WIDTH + 1)'(a_exp) + (EXP_WIDTH + 1)'(b_exp);
        s1_zero_next  = (a_frac == '0) || (b_frac == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_mul_reg    <= (command == cfam_pkg::CMD_MUL);
            s1_a_sign_reg <= a_sign;
            s1_b_sign_reg <= b_sign;
            s1_a_frac_reg <= a_frac;
            s1_b_frac_reg <= b_frac;
            s1_a_gt_reg   <= s1_a_gt_next;
            s1_diff_reg   <= s1_diff_next;
            s1_e_big_reg  <= s1_e_big_next;
            s1_prod_reg   <= s1_prod_next;
            s1_esum_reg   <= s1_esum_next;
            s1_zero_reg   <= s1_zero_next;
        end
    end

    // stage 2: align the smaller operand, leading-one search on the product
    always_comb
    begin
        logic                  far;
        logic [FRAC_WIDTH-1:0] small_frac;
        far        = 32'(s1_diff_reg) >= 32'(FRAC_WIDTH);
        small_frac = s1_a_gt_reg ? s1_b_frac_reg : s1_a_frac_reg;
        small_frac = far ? '0 : (small_frac >> s1_diff_reg);
        s2_af_next = s1_a_gt_reg ? s1_a_frac_reg : small_frac;
        s2_bf_next = s1_a_gt_reg ? small_frac : s1_b_frac_reg;

        // only a leading one above the top fraction bit needs a shift
        s2_shift_next = '0;
        for (int i = FRAC_WIDTH; i < PW; i++)
        begin
            if (s1_prod_reg[i])
            begin
                s2_shift_next = SHIFT_W'(i - (FRAC_WIDTH - 1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_mul_reg    <= s1_mul_reg;
            s2_a_sign_reg <= s1_a_sign_reg;
            s2_b_sign_reg <= s1_b_sign_reg;
            s2_af_reg     <= s2_af_next;
            s2_bf_reg     <= s2_bf_next;
            s2_e_big_reg  <= s1_e_big_reg;
            s2_prod_reg   <= s1_prod_reg;
            s2_esum_reg   <= s1_esum_reg;
            s2_zero_reg   <= s1_zero_reg;
            s2_shift_reg  <= s2_shift_next;
        end
    end

    // stage 3: add or subtract magnitudes, or normalize the product
    always_comb
    begin
        logic [FRAC_WIDTH:0]   sum;
        logic                  a_lt_b;
        logic [FRAC_WIDTH-1:0] f;
        logic [EXP_WIDTH-1:0]  e;
        logic                  s;
        logic [EXT_W-1:0]      e_tot;
        logic [PW-1:0]         p;

        sum    = (FRAC_WIDTH + 1)'(s2_af_reg) + (FRAC_WIDTH + 1)'(s2_bf_reg);
        a_lt_b = s2_af_reg < s2_bf_reg;
        e_tot  = EXT_W'(s2_esum_reg) + EXT_W'(s2_shift_reg);
        p      = s2_prod_reg >> s2_shift_reg;
        f      = '0;
        e      = s2_e_big_reg;
        s      = 1'b0;

        res_sign_next     = 1'b0;
        res_exp_next      = '0;
        res_frac_next     = '0;
        exp_overflow_next = 1'b0;

        if (s2_mul_reg)
        begin
            if (s2_zero_reg)
            begin
                // zero factor gives plain zero
            end
            else if (e_tot > EXT_W'(EXP_MAX))
            begin
                exp_overflow_next = 1'b1;
            end
            else
            begin
                res_sign_next = s2_a_sign_reg ^ s2_b_sign_reg;
                res_exp_next  = e_tot[EXP_WIDTH-1:0];
                res_frac_next = p[FRAC_WIDTH-1:0];
            end
        end
        else if (s2_a_sign_reg == s2_b_sign_reg && sum[FRAC_WIDTH] && e == EXP_MAX)
        begin
            exp_overflow_next = 1'b1;
        end
        else
        begin
            if (s2_a_sign_reg == s2_b_sign_reg)
            begin
                s = s2_a_sign_reg;
                if (sum[FRAC_WIDTH])
                begin
                    // carry moves into the top fraction bit
                    f = sum[FRAC_WIDTH:1];
                    e = e + EXP_WIDTH'(1);
                end
                else
                begin
                    f = sum[FRAC_WIDTH-1:0];
                end
            end
            else if (s2_a_sign_reg)
            begin
                s = !a_lt_b;
                f = a_lt_b ? (s2_bf_reg - s2_af_reg) : (s2_af_reg - s2_bf_reg);
            end
            else
            begin
                // equal magnitudes come out negative
                s = a_lt_b || (s2_af_reg == s2_bf_reg);
                f = s ? (s2_bf_reg - s2_af_reg) : (s2_af_reg - s2_bf_reg);
            end
            res_sign_next = s;
            res_exp_next  = (f == '0) ? '0 : e;
            res_frac_next = f;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && s2_valid_reg)
        begin
            res_sign_reg     <= res_sign_next;
            res_exp_reg      <= res_exp_next;
            res_frac_reg     <= res_frac_next;
            exp_overflow_reg <= exp_overflow_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign res_sign     = res_sign_reg;
    assign res_exp      = res_exp_reg;
    assign res_frac     = res_frac_reg;
    assign exp_overflow = exp_overflow_reg;

    // an overflowed result is all zero
    a_overflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && exp_overflow |-> !res_sign && res_exp == '0 && res_frac == '0)
        else $error("overflow result is not zero");

    // a zero fraction always carries exponent zero
    a_zero_exp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && res_frac == '0 |-> res_exp == '0)
        else $error("zero fraction with nonzero exponent");

    // an input transfer always lands in the first stage
    a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> s1_valid_reg)
        else $error("input transfer lost");

    // a blocked middle stage keeps its item
    a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !out_ready |=> s2_valid_reg && $stable(s2_prod_reg))
        else $error("stage 2 item dropped under stall");

endmodule

@@ verif/cfam_result_checker.sv @@
`timescale 1ns / 1ps

module cfam_result_checker #(
    parameter int FRAC_WIDTH = 18,
    parameter int EXP_WIDTH  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic                  command,
    input  logic                  a_sign,
    input  logic [EXP_WIDTH-1:0]  a_exp,
    input  logic [FRAC_WIDTH-1:0] a_frac,
    input  logic                  b_sign,
    input  logic [EXP_WIDTH-1:0]  b_exp,
    input  logic [FRAC_WIDTH-1:0] b_frac,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic                  res_sign,
    input  logic [EXP_WIDTH-1:0]  res_exp,
    input  logic [FRAC_WIDTH-1:0] res_frac,
    input  logic                  exp_overflow,
    output int                    error_count,
    output int                    pending_count
);

    localparam logic [EXP_WIDTH-1:0] EXP_MAX = '1;

    typedef struct packed {
        logic                  sign;
        logic [EXP_WIDTH-1:0]  exp;
        logic [FRAC_WIDTH-1:0] frac;
        logic                  ovf;
    } fp_result_t;

    fp_result_t expected_results[$];

    function automatic fp_result_t fp_overflow_result();
        fp_result_t r;
        r      = '0;
        r.ovf  = 1'b1;
        return r;
    endfunction

    function automatic fp_result_t fp_add(input logic as, input logic [EXP_WIDTH-1:0] ae,
                                          input logic [FRAC_WIDTH-1:0] af, input logic bs,
                                          input logic [EXP_WIDTH-1:0] be,
                                          input logic [FRAC_WIDTH-1:0] bf);
        fp_result_t            r;
        logic [EXP_WIDTH-1:0]  diff;
        logic [EXP_WIDTH:0]    e;
        logic [FRAC_WIDTH:0]   f;
        logic [FRAC_WIDTH-1:0] xa;
        logic [FRAC_WIDTH-1:0] xb;
        logic                  s;
        xa = af;
        xb = bf;
        // smaller exponent operand is aligned, bits shifted out are lost
        if (ae > be)
        begin
            diff = ae - be;
            xb   = (diff >= FRAC_WIDTH) ? '0 : bf >> diff;
            e    = {1'b0, ae};
        end
        else
        begin
            diff = be - ae;
            xa   = (diff >= FRAC_WIDTH) ? '0 : af >> diff;
            e    = {1'b0, be};
        end
        if (as == bs)
        begin
            s = as;
            f = {1'b0, xa} + {1'b0, xb};
            if (f[FRAC_WIDTH])
            begin
                if (e == {1'b0, EXP_MAX})
                    return fp_overflow_result();
                f = f >> 1;
                e = e + 1'b1;
            end
        end
        else if (as)
        begin
            if (xa < xb)
            begin
                s = 1'b0;
                f = {1'b0, xb - xa};
            end
            else
            begin
                s = 1'b1;
                f = {1'b0, xa - xb};
            end
        end
        else
        begin
            if (xb < xa)
            begin
                s = 1'b0;
                f = {1'b0, xa - xb};
            end
            else
            begin
                s = 1'b1;
                f = {1'b0, xb - xa};
            end
        end
        if (f == '0)
            e = '0;
        r.sign = s;
        r.exp  = e[EXP_WIDTH-1:0];
        r.frac = f[FRAC_WIDTH-1:0];
        r.ovf  = 1'b0;
        return r;
    endfunction

    function automatic fp_result_t fp_mul(input logic as, input logic [EXP_WIDTH-1:0] ae,
                                          input logic [FRAC_WIDTH-1:0] af, input logic bs,
                                          input logic [EXP_WIDTH-1:0] be,
                                          input logic [FRAC_WIDTH-1:0] bf);
        fp_result_t              r;
        logic [EXP_WIDTH+1:0]    e;
        logic [2*FRAC_WIDTH-1:0] p;
        int                      lead;
        int                      shift;
        r = '0;
        if (af == '0 || bf == '0)
            return r;
        e    = {2'b00, ae} + {2'b00, be};
        p    = {{FRAC_WIDTH{1'b0}}, af} * {{FRAC_WIDTH{1'b0}}, bf};
        lead = 0;
        for (int i = 0; i < 2 * FRAC_WIDTH; i++)
        begin
            if (p[i])
                lead = i;
        end
        shift = (lead > FRAC_WIDTH - 1) ? lead - (FRAC_WIDTH - 1) : 0;
        p     = p >> shift;
        e     = e + (EXP_WIDTH + 2)'(shift);
        if (e > {2'b00, EXP_MAX})
            return fp_overflow_result();
        r.sign = as ^ bs;
        r.exp  = e[EXP_WIDTH-1:0];
        r.frac = p[FRAC_WIDTH-1:0];
        return r;
    endfunction

    function automatic fp_result_t predict_fp_result(input cfam_pkg::cmd_t op, input logic as,
                                                     input logic [EXP_WIDTH-1:0] ae,
                                                     input logic [FRAC_WIDTH-1:0] af,
                                                     input logic bs,
                                                     input logic [EXP_WIDTH-1:0] be,
                                                     input logic [FRAC_WIDTH-1:0] bf);
        if (op == cfam_pkg::CMD_MUL)
            return fp_mul(as, ae, af, bs, be, bf);
        return fp_add(as, ae, af, bs, be, bf);
    endfunction

    always @(posedge clk)
    begin
        fp_result_t want;
        fp_result_t got;
        if (rst_n)
        begin
            // results are checked before the new operand transfer is queued
            if (out_valid && !out_stall)
            begin
                got = '{res_sign, res_exp, res_frac, exp_overflow};
                if (expected_results.size() == 0)
                begin
                    error_count = error_count + 1;
                    if (error_count <= 10)
                        $display("unexpected result: sign %0d exp %h frac %h ovf %0d",
                                 got.sign, got.exp, got.frac, got.ovf);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.sign !== want.sign || got.exp !== want.exp ||
                        got.frac !== want.frac || got.ovf !== want.ovf)
                    begin
                        error_count = error_count + 1;
                        if (error_count <= 10)
                            $display("mismatch: expected sign %0d exp %h frac %h ovf %0d,",
                                     want.sign, want.exp, want.frac, want.ovf,
                                     " got sign %0d exp %h frac %h ovf %0d",
                                     got.sign, got.exp, got.frac, got.ovf);
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(
                    predict_fp_result(cfam_pkg::cmd_t'(command), a_sign, a_exp, a_frac,
                                      b_sign, b_exp, b_frac));
            pending_count = expected_results.size();
        end
    end

endmodule

@@ verif/tb_custom_float_add_multiply.sv @@
`timescale 1ns / 1ps

module tb_custom_float_add_multiply;

    localparam int FRAC_WIDTH  = 18;
    localparam int EXP_WIDTH   = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 488;

    localparam logic [EXP_WIDTH-1:0]  EXP_MAX  = '1;
    localparam logic [FRAC_WIDTH-1:0] FRAC_MAX = '1;
    localparam logic [FRAC_WIDTH-1:0] FRAC_TOP = FRAC_WIDTH'(1) << (FRAC_WIDTH - 1);

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  command;
    logic                  a_sign;
    logic [EXP_WIDTH-1:0]  a_exp;
    logic [FRAC_WIDTH-1:0] a_frac;
    logic                  b_sign;
    logic [EXP_WIDTH-1:0]  b_exp;
    logic [FRAC_WIDTH-1:0] b_frac;
    logic                  out_valid;
    logic                  out_stall;
    logic                  res_sign;
    logic [EXP_WIDTH-1:0]  res_exp;
    logic [FRAC_WIDTH-1:0] res_frac;
    logic                  exp_overflow;

    int error_count;
    int pending_count;
    int sender_idle_pct;
    int receiver_stall_pct;
    int cycle_count;

    custom_float_add_multiply #(
        .FRAC_WIDTH (FRAC_WIDTH),
        .EXP_WIDTH  (EXP_WIDTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .a_sign       (a_sign),
        .a_exp        (a_exp),
        .a_frac       (a_frac),
        .b_sign       (b_sign),
        .b_exp        (b_exp),
        .b_frac       (b_frac),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .res_sign     (res_sign),
        .res_exp      (res_exp),
        .res_frac     (res_frac),
        .exp_overflow (exp_overflow)
    );

    cfam_result_checker #(
        .FRAC_WIDTH (FRAC_WIDTH),
        .EXP_WIDTH  (EXP_WIDTH)
    ) checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .a_sign        (a_sign),
        .a_exp         (a_exp),
        .a_frac        (a_frac),
        .b_sign        (b_sign),
        .b_exp         (b_exp),
        .b_frac        (b_frac),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .res_sign      (res_sign),
        .res_exp       (res_exp),
        .res_frac      (res_frac),
        .exp_overflow  (exp_overflow),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    initial
        clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(99) < receiver_stall_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // one operand transfer, called and returning at a falling edge
    task automatic send_operands(input cfam_pkg::cmd_t op, input logic as,
                                 input logic [EXP_WIDTH-1:0] ae,
                                 input logic [FRAC_WIDTH-1:0] af, input logic bs,
                                 input logic [EXP_WIDTH-1:0] be,
                                 input logic [FRAC_WIDTH-1:0] bf);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command  <= op;
        a_sign   <= as;
        a_exp    <= ae;
        a_frac   <= af;
        b_sign   <= bs;
        b_exp    <= be;
        b_frac   <= bf;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // hold off the sender until every queued result has come out
    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
    endtask

    function automatic logic [EXP_WIDTH-1:0] random_exp();
        unique case ($urandom_range(3))
            0:       return EXP_WIDTH'($urandom);
            1:       return EXP_WIDTH'($urandom_range(0, 15));
            2:       return EXP_MAX - EXP_WIDTH'($urandom_range(0, 15));
            default: return EXP_WIDTH'($urandom_range(0, 32767));
        endcase
    endfunction

    function automatic logic [FRAC_WIDTH-1:0] random_frac();
        unique case ($urandom_range(7))
            0:       return '0;
            1:       return FRAC_MAX;
            2:       return FRAC_WIDTH'($urandom_range(1, 255));
            3:       return FRAC_WIDTH'(1) << $urandom_range(0, FRAC_WIDTH - 1);
            default: return FRAC_WIDTH'($urandom);
        endcase
    endfunction

    task automatic send_random_item();
        cfam_pkg::cmd_t        op;
        logic [EXP_WIDTH-1:0]  ae;
        logic [EXP_WIDTH-1:0]  be;
        logic [FRAC_WIDTH-1:0] af;
        logic [FRAC_WIDTH-1:0] bf;
        op = $urandom_range(1) ? cfam_pkg::CMD_MUL : cfam_pkg::CMD_ADD;
        ae = random_exp();
        // nearby exponents keep both operands in play for the aligned add
        if ($urandom_range(1))
            be = ae + EXP_WIDTH'($urandom_range(0, 40)) - EXP_WIDTH'(20);
        else
            be = random_exp();
        af = random_frac();
        bf = ($urandom_range(7) == 0) ? af : random_frac();
        send_operands(op, 1'($urandom), ae, af, 1'($urandom), be, bf);
    endtask

    initial
    begin
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        command            = 1'b0;
        a_sign             = 1'b0;
        a_exp              = '0;
        a_frac             = '0;
        b_sign             = 1'b0;
        b_exp              = '0;
        b_frac             = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // adds: zeros, cancellation, carries, overflow, alignment
        send_operands(cfam_pkg::CMD_ADD, 1'b0, '0, '0, 1'b0, '0, '0);
        send_operands(cfam_pkg::CMD_ADD, 1'b1, '0, '0, 1'b1, '0, '0);
        send_operands(cfam_pkg::CMD_ADD, 1'b0, 16'd40, 18'h12345, 1'b1, 16'd40, 18'h12345);
        send_operands(cfam_pkg::CMD_ADD, 1'b1, 16'd40, 18'h12345, 1'b0, 16'd40, 18'h12345);
        send_operands(cfam_pkg::CMD_ADD, 1'b0, EXP_MAX, FRAC_MAX, 1'b0, EXP_MAX, FRAC_MAX);
        send_operands(cfam_pkg::CMD_ADD, 1'b1, 16'd100, FRAC_TOP, 1'b1, 16'd100, FRAC_TOP);
        send_operands(cfam_pkg::CMD_ADD, 1'b0, 16'd100, FRAC_MAX, 1'b0, 16'd82, FRAC_MAX);
        send_operands(cfam_pkg::CMD_ADD, 1'b0, 16'd100, FRAC_MAX, 1'b1, 16'd83, FRAC_MAX);
        send_operands(cfam_pkg::CMD_ADD, 1'b1, 16'd5, 18'h00010, 1'b0, 16'd9, 18'h20000);
        send_operands(cfam_pkg::CMD_ADD, 1'b0, 16'd9, 18'h00100, 1'b1, 16'd9, 18'h30000);
        send_operands(cfam_pkg::CMD_ADD, 1'b1, '0, FRAC_MAX, 1'b0, EXP_MAX, 18'h00001);
        send_operands(cfam_pkg::CMD_ADD, 1'b0, EXP_MAX, '0, 1'b1, EXP_MAX, '0);
        // multiplies: zero factors, small products, normalize, overflow
        send_operands(cfam_pkg::CMD_MUL, 1'b1, 16'd7, '0, 1'b0, 16'd3, FRAC_MAX);
        send_operands(cfam_pkg::CMD_MUL, 1'b0, 16'd7, FRAC_MAX, 1'b1, EXP_MAX, '0);
        send_operands(cfam_pkg::CMD_MUL, 1'b1, 16'd3, 18'h00001, 1'b1, 16'd4, 18'h00001);
        send_operands(cfam_pkg::CMD_MUL, 1'b0, 16'd3, 18'h00200, 1'b1, 16'd4, 18'h00100);
        send_operands(cfam_pkg::CMD_MUL, 1'b1, 16'd10, FRAC_MAX, 1'b0, 16'd20, FRAC_MAX);
        send_operands(cfam_pkg::CMD_MUL, 1'b0, EXP_MAX, 18'h00001, 1'b0, 16'd1, 18'h00001);
        send_operands(cfam_pkg::CMD_MUL, 1'b0, EXP_MAX, FRAC_TOP, 1'b0, '0, 18'h00002);
        send_operands(cfam_pkg::CMD_MUL, 1'b1, EXP_MAX - 16'd18, FRAC_MAX, 1'b1, '0, FRAC_MAX);
        send_operands(cfam_pkg::CMD_MUL, 1'b1, EXP_MAX, FRAC_MAX, 1'b0, EXP_MAX, FRAC_MAX);
        send_operands(cfam_pkg::CMD_MUL, 1'b0, '0, FRAC_TOP, 1'b1, '0, FRAC_TOP);
        drain_results();

        for (int phase = 0; phase < 4; phase++)
        begin
            unique case (phase)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 46;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 46;
                end
                default:
                begin
                    sender_idle_pct    = 10;
                    receiver_stall_pct = 10;
                end
            endcase
            repeat (PHASE_ITEMS)
                send_random_item();
            drain_results();
        end

        repeat (8) @(negedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
